// ===== sv/priority_round_robin_scheduler_defines.svh =====
// assertion macros for the scheduler checker
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRRS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prrs check failed");

// next-cycle implication, sampled on clk, off during reset
`define PRRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prrs check failed");

`endif

// ===== sv/prrs_pkg.sv =====
`default_nettype none

package prrs_pkg;

	typedef enum logic [2:0] {
		ST_INVALID,
		ST_READY,
		ST_RUNNING,
		ST_SLEEPING,
		ST_EXITED
	} slot_state_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_NONE,
		STAT_IGNORED
	} status_t;

	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_YIELD  = 3'd1;
	localparam logic [2:0] CMD_TICK   = 3'd2;
	localparam logic [2:0] CMD_EXIT   = 3'd3;
	localparam logic [2:0] CMD_SLEEP  = 3'd4;
	localparam logic [2:0] CMD_WAKE   = 3'd5;

	typedef enum logic [1:0] {
		ADDR_CUR,
		ADDR_TGT,
		ADDR_NEW
	} addr_sel_t;

	typedef struct packed {
		logic        in_latch;
		logic        addr_load;
		addr_sel_t   addr_sel;
		logic        st_we;
		slot_state_t st_wdata;
		logic        slot_we;
		logic        used_inc;
		logic        rem_we;
		logic        walk_init;
		logic        walk_step;
		logic        pick;
		logic        out_load;
		status_t     res_status;
		logic        res_disp;
		logic        res_created;
	} dp_cmd_t;

	typedef struct packed {
		logic        used_zero;
		logic        full;
		logic        cur_valid;
		logic        tgt_ok;
		slot_state_t st_rd;
		logic        rem_zero;
		logic        walk_busy;
		logic        found;
		logic        out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/prrs_dp.sv =====
`default_nettype none

module prrs_dp #(
	parameter int TASK_SLOTS = 16,
	parameter int SLICE_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire prrs_pkg::dp_cmd_t cmd,
	output prrs_pkg::dp_stat_t    stat,
	input  wire logic [7:0]       priority_req,
	input  wire logic [15:0]      slice_length,
	input  wire logic [3:0]       target_task,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic [3:0]            task_index,
	output logic                  running_valid,
	output logic                  dispatched
);

	localparam int IDX_W = $clog2(TASK_SLOTS);
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	// latched item fields
	logic [7:0]            prio_q;
	logic [SLICE_BITS-1:0] slice_q;
	logic [3:0]            tgt_q;

	// slot tables
	prrs_pkg::slot_state_t st_q [TASK_SLOTS];
	logic [7:0]            prio_mem [TASK_SLOTS];
	logic [SLICE_BITS-1:0] slice_mem [TASK_SLOTS];
	logic [SLICE_BITS-1:0] rem_mem [TASK_SLOTS];
	logic [7:0]            prio_rd_q;
	logic [SLICE_BITS-1:0] slice_rd_q;
	logic [SLICE_BITS-1:0] rem_rd_q;
	logic [SLICE_BITS-1:0] rem_dec;
	logic [SLICE_BITS-1:0] rem_wdata;

	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] cur_q;
	logic             cur_v_q;

	// walk
	logic [CNT_W-1:0] left_q;
	logic             vld_s1;
	logic             rdy_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [7:0]       best_q;
	logic [IDX_W-1:0] pick_q;
	logic [CNT_W-1:0] cur_inc;
	logic [CNT_W-1:0] addr_inc;
	logic [IDX_W-1:0] start_idx;
	logic [IDX_W-1:0] walk_next;
	logic [IDX_W-1:0] addr_mux;
	logic             take;

	logic out_valid_q;

	assign cur_inc   = CNT_W'(cur_q) + CNT_W'(1);
	assign addr_inc  = CNT_W'(addr_q) + CNT_W'(1);
	assign start_idx = (!cur_v_q || cur_inc == used_q) ? '0 : IDX_W'(cur_inc);
	assign walk_next = (addr_inc == used_q) ? '0 : IDX_W'(addr_inc);
	assign rem_dec   = rem_rd_q - SLICE_BITS'(1);
	assign rem_wdata = (rem_dec == '0) ? slice_rd_q : rem_dec;
	assign take      = vld_s1 && rdy_s1 && (!found_q || prio_rd_q < best_q);

	always_comb begin
		unique case (cmd.addr_sel)
			prrs_pkg::ADDR_TGT: addr_mux = IDX_W'(tgt_q);
			prrs_pkg::ADDR_NEW: addr_mux = IDX_W'(used_q);
			default:            addr_mux = cur_q;
		endcase
	end

	always_comb begin
		stat.used_zero = (used_q == '0);
		stat.full      = (used_q == CNT_W'(TASK_SLOTS));
		stat.cur_valid = cur_v_q;
		stat.tgt_ok    = (32'(tgt_q) < TASK_SLOTS);
		stat.st_rd     = st_q[addr_q];
		stat.rem_zero  = (rem_dec == '0);
		stat.walk_busy = (left_q != '0) || vld_s1;
		stat.found     = found_q;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.in_latch) begin
			prio_q  <= priority_req;
			slice_q <= SLICE_BITS'(slice_length);
			tgt_q   <= target_task;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.slot_we) begin
			prio_mem[addr_q]  <= prio_q;
			slice_mem[addr_q] <= slice_q;
		end
		if (cmd.slot_we) begin
			rem_mem[addr_q] <= slice_q;
		end else if (cmd.rem_we) begin
			rem_mem[addr_q] <= rem_wdata;
		end
		prio_rd_q  <= prio_mem[addr_q];
		slice_rd_q <= slice_mem[addr_q];
		rem_rd_q   <= rem_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				st_q[i] <= prrs_pkg::ST_INVALID;
			end
		end else begin
			if (cmd.slot_we) begin
				st_q[addr_q] <= prrs_pkg::ST_READY;
			end
			if (cmd.st_we) begin
				st_q[addr_q] <= cmd.st_wdata;
			end
			if (cmd.pick) begin
				st_q[pick_q] <= prrs_pkg::ST_RUNNING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			used_q      <= '0;
			cur_q       <= '0;
			cur_v_q     <= 1'b0;
			left_q      <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.addr_load) begin
				addr_q <= addr_mux;
			end else if (cmd.walk_init) begin
				addr_q <= start_idx;
			end else if (cmd.walk_step && left_q != '0) begin
				addr_q <= walk_next;
			end
			if (cmd.used_inc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.pick) begin
				cur_q   <= pick_q;
				cur_v_q <= 1'b1;
			end
			if (cmd.walk_init) begin
				left_q  <= used_q;
				found_q <= 1'b0;
			end else begin
				if (cmd.walk_step && left_q != '0) begin
					left_q <= left_q - CNT_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			vld_s1 <= cmd.walk_step && (left_q != '0);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rdy_s1 <= (st_q[addr_q] == prrs_pkg::ST_READY);
		idx_s1 <= addr_q;
		if (take) begin
			best_q <= prio_rd_q;
			pick_q <= idx_s1;
		end
		if (cmd.out_load) begin
			status        <= cmd.res_status;
			dispatched    <= cmd.res_disp;
			running_valid <= cur_v_q;
			if (cmd.res_created) begin
				task_index <= 4'(addr_q);
			end else if (cur_v_q) begin
				task_index <= 4'(cur_q);
			end else begin
				task_index <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/prrs_ctrl.sv =====
`default_nettype none

module prrs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        command,
	input  wire prrs_pkg::dp_stat_t stat,
	output prrs_pkg::dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CREATE,
		S_TICK_RD,
		S_TICK_WR,
		S_CUR_MARK,
		S_WAKE,
		S_SCHED,
		S_WALK,
		S_PICK,
		S_RESULT
	} ctrl_state_t;

	ctrl_state_t       state_q;
	logic [2:0]        cmd_q;
	prrs_pkg::status_t res_status_q;
	logic              res_disp_q;
	logic              res_created_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.addr_sel    = prrs_pkg::ADDR_CUR;
		cmd.st_wdata    = prrs_pkg::ST_READY;
		cmd.res_status  = res_status_q;
		cmd.res_disp    = res_disp_q;
		cmd.res_created = res_created_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_latch = in_valid;
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					prrs_pkg::CMD_CREATE: begin
						cmd.addr_load = !stat.full;
						cmd.addr_sel  = prrs_pkg::ADDR_NEW;
					end
					prrs_pkg::CMD_YIELD, prrs_pkg::CMD_EXIT: begin
						cmd.addr_load = 1'b1;
					end
					prrs_pkg::CMD_TICK, prrs_pkg::CMD_SLEEP: begin
						cmd.addr_load = stat.cur_valid;
					end
					prrs_pkg::CMD_WAKE: begin
						cmd.addr_load = stat.tgt_ok;
						cmd.addr_sel  = prrs_pkg::ADDR_TGT;
					end
					default: begin
					end
				endcase
			end
			S_CREATE: begin
				cmd.slot_we  = 1'b1;
				cmd.used_inc = 1'b1;
			end
			S_TICK_WR: begin
				cmd.rem_we = 1'b1;
			end
			S_CUR_MARK: begin
				cmd.st_we    = stat.cur_valid;
				cmd.st_wdata = (cmd_q == prrs_pkg::CMD_EXIT) ? prrs_pkg::ST_EXITED
				                                             : prrs_pkg::ST_SLEEPING;
			end
			S_WAKE: begin
				cmd.st_we = (stat.st_rd == prrs_pkg::ST_SLEEPING);
			end
			S_SCHED: begin
				cmd.st_we     = !stat.used_zero && stat.cur_valid &&
				                (stat.st_rd == prrs_pkg::ST_RUNNING);
				cmd.walk_init = !stat.used_zero;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
			end
			S_PICK: begin
				cmd.pick = stat.found;
			end
			S_RESULT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= prrs_pkg::CMD_CREATE;
			res_status_q  <= prrs_pkg::STAT_IGNORED;
			res_disp_q    <= 1'b0;
			res_created_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q         <= command;
						res_disp_q    <= 1'b0;
						res_created_q <= 1'b0;
						state_q       <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_status_q <= prrs_pkg::STAT_IGNORED;
					state_q      <= S_RESULT;
					unique case (cmd_q)
						prrs_pkg::CMD_CREATE: begin
							if (stat.full) begin
								res_status_q <= prrs_pkg::STAT_FULL;
							end else begin
								state_q <= S_CREATE;
							end
						end
						prrs_pkg::CMD_YIELD: begin
							state_q <= S_SCHED;
						end
						prrs_pkg::CMD_TICK: begin
							if (stat.cur_valid) begin
								state_q <= S_TICK_RD;
							end
						end
						prrs_pkg::CMD_EXIT: begin
							state_q <= S_CUR_MARK;
						end
						prrs_pkg::CMD_SLEEP: begin
							if (stat.cur_valid) begin
								state_q <= S_CUR_MARK;
							end
						end
						prrs_pkg::CMD_WAKE: begin
							if (stat.tgt_ok) begin
								state_q <= S_WAKE;
							end
						end
						default: begin
						end
					endcase
				end
				S_CREATE: begin
					res_status_q  <= prrs_pkg::STAT_OK;
					res_created_q <= 1'b1;
					state_q       <= S_RESULT;
				end
				S_TICK_RD: begin
					if (stat.st_rd == prrs_pkg::ST_RUNNING) begin
						state_q <= S_TICK_WR;
					end else begin
						res_status_q <= prrs_pkg::STAT_IGNORED;
						state_q      <= S_RESULT;
					end
				end
				S_TICK_WR: begin
					if (stat.rem_zero) begin
						state_q <= S_SCHED;
					end else begin
						res_status_q <= prrs_pkg::STAT_OK;
						state_q      <= S_RESULT;
					end
				end
				S_CUR_MARK: begin
					state_q <= S_SCHED;
				end
				S_WAKE: begin
					res_status_q <= (stat.st_rd == prrs_pkg::ST_SLEEPING) ? prrs_pkg::STAT_OK
					                                                   : prrs_pkg::STAT_IGNORED;
					state_q      <= S_RESULT;
				end
				S_SCHED: begin
					if (stat.used_zero) begin
						res_status_q <= prrs_pkg::STAT_NONE;
						state_q      <= S_RESULT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!stat.walk_busy) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					res_status_q <= stat.found ? prrs_pkg::STAT_OK : prrs_pkg::STAT_NONE;
					res_disp_q   <= stat.found;
					state_q      <= S_RESULT;
				end
				S_RESULT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/priority_round_robin_scheduler.sv =====
// Task-slot scheduler with priority and round-robin selection.
// Input channel (in_valid / in_stall) takes one command item: create, yield,
// tick, exit, sleep or wake, with the priority, slice and target fields.
// Output channel (out_valid / out_stall) returns exactly one result item per
// command: status, task index, running flag and dispatched flag.
// One item is worked on at a time; in_stall is high from acceptance until
// the result has been loaded into the output register.
// Rescheduling on a non-empty table walks the filled slots one per cycle
// through the registered table read; the next item is accepted in the idle
// state, after the result of the last one has been loaded.
// The output register holds a result while out_stall is high; the next item
// may be accepted meanwhile, and its result waits until the register frees.
// Reset clears all slot states, the fill count and the running task; the
// priority and slice tables are written by create before any read.
`default_nettype none

module priority_round_robin_scheduler #(
	parameter int TASK_SLOTS = 16,
	parameter int SLICE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  priority_req,
	input  wire logic [15:0] slice_length,
	input  wire logic [3:0]  target_task,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       task_index,
	output logic             running_valid,
	output logic             dispatched
);

	prrs_pkg::dp_cmd_t  cmd;
	prrs_pkg::dp_stat_t stat;

	prrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	prrs_dp #(
		.TASK_SLOTS (TASK_SLOTS),
		.SLICE_BITS (SLICE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.priority_req  (priority_req),
		.slice_length  (slice_length),
		.target_task   (target_task),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.task_index    (task_index),
		.running_valid (running_valid),
		.dispatched    (dispatched)
	);

endmodule

`default_nettype wire

// ===== sv/prrs_checker.sv =====
`default_nettype none

`include "priority_round_robin_scheduler_defines.svh"

module prrs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic       running_valid,
	input wire logic       dispatched
);

	// one item in flight
	`PRRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// held result stays put
	`PRRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))

	// a dispatch leaves a running task
	`PRRS_ASSERT_SAME(a_disp_running, out_valid && dispatched,
		running_valid && status == prrs_pkg::STAT_OK)

	// no dispatch with none or full status
	`PRRS_ASSERT_SAME(a_none_no_disp,
		out_valid && (status == prrs_pkg::STAT_NONE || status == prrs_pkg::STAT_FULL),
		!dispatched)

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (.*);

`default_nettype wire
